FILE: hw/rtl/y2rgb_pkg.sv
package y2rgb_pkg;

	// Q15 colour conversion coefficients.
	localparam int COEF_RV_I   = 37221;
	localparam int COEF_GU_I   = 12975;
	localparam int COEF_GV_I   = 18949;
	localparam int COEF_BU_I   = 66883;
	localparam int FRAC_BITS   = 15;

	localparam int PIX_W  = 8;
	localparam int PROD_W = 26;
	localparam int OFF_W  = 10;
	localparam int SUM_W  = 11;
	localparam int WORD_W = 32;

	localparam logic signed [PROD_W-1:0] COEF_RV = PROD_W'(COEF_RV_I);
	localparam logic signed [PROD_W-1:0] COEF_GU = PROD_W'(COEF_GU_I);
	localparam logic signed [PROD_W-1:0] COEF_GV = PROD_W'(COEF_GV_I);
	localparam logic signed [PROD_W-1:0] COEF_BU = PROD_W'(COEF_BU_I);

	// Output format codes.
	localparam logic [1:0] FMT_RGB  = 2'd0;
	localparam logic [1:0] FMT_BGR  = 2'd1;
	localparam logic [1:0] FMT_ARGB = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_ALPHA  = 1'b1;

	localparam logic [1:0]       FORMAT_RESET = FMT_RGB;
	localparam logic [PIX_W-1:0] ALPHA_RESET  = 8'hFF;

	// Chroma contributions shared by both lanes.
	typedef struct packed {
		logic signed [OFF_W-1:0] r_off;
		logic signed [OFF_W-1:0] g_off;
		logic signed [OFF_W-1:0] b_off;
	} chroma_t;

	typedef struct packed {
		logic [1:0]       format;
		logic [PIX_W-1:0] alpha;
	} fmt_cfg_t;

endpackage

FILE: hw/rtl/yuyv_to_rgb_pixel_pair_top.sv
// YUYV 4:2:2 macropixel to packed RGB pixel pair converter.
// Each accepted word passes the first-stage registers, then the output register, where it leaves with done high.
// Throughput: one word per cycle; busy is never high, set by the two-stage pipeline
// (chroma products, then the two per-pixel lanes into the output register).
// Reset (arst_n low, asynchronous) empties the pipeline and sets RGB format, alpha 255.
// The receiver cannot stall: each result is shown for exactly one cycle.
module yuyv_to_rgb_pixel_pair_top
	import y2rgb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [PIX_W-1:0]  luma_first,
	input  logic [PIX_W-1:0]  chroma_blue,
	input  logic [PIX_W-1:0]  luma_second,
	input  logic [PIX_W-1:0]  chroma_red,
	output logic              done,
	output logic [WORD_W-1:0] pixel_first,
	output logic [WORD_W-1:0] pixel_second
);

	fmt_cfg_t          cfg_q;
	logic              accept;
	logic              v_s1;
	logic              done_q;
	logic [PIX_W-1:0]  luma0_s1;
	logic [PIX_W-1:0]  luma1_s1;
	chroma_t           chroma_s1;
	logic [WORD_W-1:0] lane0_pix;
	logic [WORD_W-1:0] lane1_pix;
	logic [WORD_W-1:0] pix0_q;
	logic [WORD_W-1:0] pix1_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.format <= FORMAT_RESET;
			cfg_q.alpha  <= ALPHA_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_FORMAT: cfg_q.format <= pwdata[1:0];
				REG_ALPHA:  cfg_q.alpha  <= pwdata[PIX_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FORMAT: prdata = {30'd0, cfg_q.format};
			REG_ALPHA:  prdata = {24'd0, cfg_q.alpha};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma0_s1 <= luma_first;
			luma1_s1 <= luma_second;
		end
	end

	y2rgb_chroma u_chroma (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.chroma_blue (chroma_blue),
		.chroma_red  (chroma_red),
		.chroma_s1   (chroma_s1)
	);

	y2rgb_lane u_lane0 (
		.luma   (luma0_s1),
		.chroma (chroma_s1),
		.cfg    (cfg_q),
		.pixel  (lane0_pix)
	);

	y2rgb_lane u_lane1 (
		.luma   (luma1_s1),
		.chroma (chroma_s1),
		.cfg    (cfg_q),
		.pixel  (lane1_pix)
	);

	// Both lanes land in the output register together so the pair leaves together.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			pix0_q <= lane0_pix;
			pix1_q <= lane1_pix;
		end
	end

	assign done         = done_q;
	assign pixel_first  = pix0_q;
	assign pixel_second = pix1_q;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without a word accepted two cycles earlier");

	a_stage_advances: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> done)
		else $error("first stage word did not reach the output");

	a_no_alpha_outside_argb: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cfg_q.format != FMT_ARGB) |->
		(pixel_first[31:24] == 8'h00 && pixel_second[31:24] == 8'h00))
		else $error("top byte set outside ARGB format");

	a_pair_shares_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(luma0_s1) == $past(luma1_s1)) |-> (pixel_first == pixel_second))
		else $error("equal luma gave different pixels in one pair");

endmodule

FILE: hw/rtl/y2rgb_chroma.sv
module y2rgb_chroma
	import y2rgb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [PIX_W-1:0] chroma_blue,
	input  logic [PIX_W-1:0] chroma_red,
	output chroma_t          chroma_s1
);

	logic signed [PIX_W-1:0]  u_c;
	logic signed [PIX_W-1:0]  v_c;
	logic signed [PROD_W-1:0] p_r;
	logic signed [PROD_W-1:0] p_g;
	logic signed [PROD_W-1:0] p_b;
	logic signed [PROD_W-1:0] sh_r;
	logic signed [PROD_W-1:0] sh_g;
	logic signed [PROD_W-1:0] sh_b;

	// Subtracting 128 from an unsigned byte is an inversion of its top bit.
	assign u_c = {~chroma_blue[PIX_W-1], chroma_blue[PIX_W-2:0]};
	assign v_c = {~chroma_red[PIX_W-1], chroma_red[PIX_W-2:0]};

	assign p_r = PROD_W'(v_c) * COEF_RV;
	assign p_g = PROD_W'(u_c) * COEF_GU + PROD_W'(v_c) * COEF_GV;
	assign p_b = PROD_W'(u_c) * COEF_BU;

	// An arithmetic shift rounds toward minus infinity.
	assign sh_r = p_r >>> FRAC_BITS;
	assign sh_g = p_g >>> FRAC_BITS;
	assign sh_b = p_b >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_s1 <= '0;
		end else if (load) begin
			chroma_s1.r_off <= sh_r[OFF_W-1:0];
			chroma_s1.g_off <= sh_g[OFF_W-1:0];
			chroma_s1.b_off <= sh_b[OFF_W-1:0];
		end
	end

endmodule

FILE: hw/rtl/y2rgb_lane.sv
module y2rgb_lane
	import y2rgb_pkg::*;
(
	input  logic [PIX_W-1:0]  luma,
	input  chroma_t           chroma,
	input  fmt_cfg_t          cfg,
	output logic [WORD_W-1:0] pixel
);

	logic signed [SUM_W-1:0] y_ext;
	logic signed [SUM_W-1:0] sum_r;
	logic signed [SUM_W-1:0] sum_g;
	logic signed [SUM_W-1:0] sum_b;
	logic [PIX_W-1:0]        r;
	logic [PIX_W-1:0]        g;
	logic [PIX_W-1:0]        b;

	function automatic logic [PIX_W-1:0] sat8(input logic signed [SUM_W-1:0] v);
		logic [PIX_W-1:0] res;
		if (v[SUM_W-1]) begin
			res = '0;
		end else if (v[SUM_W-2:PIX_W] != '0) begin
			res = '1;
		end else begin
			res = v[PIX_W-1:0];
		end
		return res;
	endfunction

	assign y_ext = SUM_W'({1'b0, luma});
	assign sum_r = y_ext + SUM_W'(chroma.r_off);
	assign sum_g = y_ext - SUM_W'(chroma.g_off);
	assign sum_b = y_ext + SUM_W'(chroma.b_off);

	assign r = sat8(sum_r);
	assign g = sat8(sum_g);
	assign b = sat8(sum_b);

	always_comb begin
		case (cfg.format)
			FMT_BGR:  pixel = {8'h00, b, g, r};
			FMT_ARGB: pixel = {cfg.alpha, r, g, b};
			default:  pixel = {8'h00, r, g, b};
		endcase
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import y2rgb_pkg::*;

	localparam int         CHROMA_ZERO = 128;
	localparam logic [1:0] FMT_UNUSED  = 2'd3;
	localparam int         PHASES      = 7;
	localparam int         RANDOM_WORDS = 148;

	typedef struct packed {
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] second;
	} pixel_pair_t;

	typedef struct packed {
		logic [7:0]        y0;
		logic [7:0]        cb;
		logic [7:0]        y1;
		logic [7:0]        cr;
		logic              has_given;
		logic [WORD_W-1:0] given_first;
		logic [WORD_W-1:0] given_second;
	} macropixel_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              start;
	logic              busy;
	logic [PIX_W-1:0]  luma_first;
	logic [PIX_W-1:0]  chroma_blue;
	logic [PIX_W-1:0]  luma_second;
	logic [PIX_W-1:0]  chroma_red;
	logic              done;
	logic [WORD_W-1:0] pixel_first;
	logic [WORD_W-1:0] pixel_second;

	// Local copy of the configuration, as the block should hold it.
	logic [1:0]       fmt_cfg;
	logic [PIX_W-1:0] alpha_cfg;

	pixel_pair_t pending_pixels[$];
	int          error_count;

	// Zero chroma leaves every channel equal to luma, so those rows are typed in.
	macropixel_row_t directed_rows [16] = '{
		'{8'd0,   8'd128, 8'd0,   8'd128, 1'b1, 32'h0000_0000, 32'h0000_0000},
		'{8'd255, 8'd128, 8'd255, 8'd128, 1'b1, 32'h00FF_FFFF, 32'h00FF_FFFF},
		'{8'd0,   8'd128, 8'd255, 8'd128, 1'b1, 32'h0000_0000, 32'h00FF_FFFF},
		'{8'd128, 8'd128, 8'd1,   8'd128, 1'b1, 32'h0080_8080, 32'h0001_0101},
		'{8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 32'h0, 32'h0},
		'{8'd0,   8'd255, 8'd255, 8'd255, 1'b0, 32'h0, 32'h0},
		'{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 32'h0, 32'h0},
		'{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 32'h0, 32'h0},
		'{8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 32'h0, 32'h0},
		'{8'd128, 8'd0,   8'd128, 8'd255, 1'b0, 32'h0, 32'h0},
		'{8'd16,  8'd127, 8'd235, 8'd129, 1'b0, 32'h0, 32'h0},
		'{8'd235, 8'd129, 8'd16,  8'd127, 1'b0, 32'h0, 32'h0},
		'{8'hAA,  8'h55,  8'h55,  8'hAA,  1'b0, 32'h0, 32'h0},
		'{8'h55,  8'hAA,  8'hAA,  8'h55,  1'b0, 32'h0, 32'h0},
		'{8'd1,   8'd1,   8'd254, 8'd254, 1'b0, 32'h0, 32'h0},
		'{8'd254, 8'd254, 8'd1,   8'd1,   1'b0, 32'h0, 32'h0}
	};

	yuyv_to_rgb_pixel_pair_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.luma_first   (luma_first),
		.chroma_blue  (chroma_blue),
		.luma_second  (luma_second),
		.chroma_red   (chroma_red),
		.done         (done),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [7:0] sat_byte(input int value);
		if (value < 0)
			return 8'd0;
		if (value > 255)
			return 8'd255;
		return value[7:0];
	endfunction

	// Arithmetic shift of a signed int rounds toward minus infinity, as required.
	function automatic logic [WORD_W-1:0] convert_pixel(input logic [7:0] y,
			input logic [7:0] cb, input logic [7:0] cr);
		int         u;
		int         v;
		logic [7:0] rb;
		logic [7:0] gb;
		logic [7:0] bb;
		u  = int'(cb) - CHROMA_ZERO;
		v  = int'(cr) - CHROMA_ZERO;
		rb = sat_byte(int'(y) + ((v * COEF_RV_I) >>> FRAC_BITS));
		gb = sat_byte(int'(y) - ((u * COEF_GU_I + v * COEF_GV_I) >>> FRAC_BITS));
		bb = sat_byte(int'(y) + ((u * COEF_BU_I) >>> FRAC_BITS));
		case (fmt_cfg)
			FMT_BGR:  return {8'h00, bb, gb, rb};
			FMT_ARGB: return {alpha_cfg, rb, gb, bb};
			default:  return {8'h00, rb, gb, bb};
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 6))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return 8'd127;
			3:       return 8'd128;
			4:       return 8'd129;
			5:       return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	// Mode 0 streams back to back, mode 1 leaves short gaps, mode 2 adds a few long ones.
	function automatic int next_gap(input int mode);
		int roll;
		roll = $urandom_range(0, 99);
		if (mode == 0 || roll < 50)
			return 0;
		if (mode == 1 || roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	task automatic apb_access(input logic is_write, input logic idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = is_write;
		paddr   = {idx, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic reg_readback(input logic idx);
		logic [31:0] rd;
		logic [31:0] want;
		apb_access(1'b0, idx, $urandom(), rd);
		want = (idx == REG_FORMAT) ? {30'd0, fmt_cfg} : {24'd0, alpha_cfg};
		if (rd !== want)
			report_mismatch($sformatf("register %0d read %08h, want %08h", idx, rd, want));
	endtask

	// Bits above the register width carry random junk to exercise masking.
	task automatic cfg_write(input logic idx, input logic [7:0] value);
		logic [31:0] wdata;
		logic [31:0] unused_rd;
		wdata = $urandom();
		if (idx == REG_FORMAT) begin
			wdata[1:0] = value[1:0];
			fmt_cfg    = value[1:0];
		end else begin
			wdata[7:0] = value;
			alpha_cfg  = value;
		end
		apb_access(1'b1, idx, wdata, unused_rd);
		reg_readback(idx);
	endtask

	task automatic send_word(input logic [7:0] y0, input logic [7:0] cb,
			input logic [7:0] y1, input logic [7:0] cr, input int gap,
			input logic has_given, input logic [WORD_W-1:0] given_first,
			input logic [WORD_W-1:0] given_second);
		pixel_pair_t pair;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       = 1'b1;
		luma_first  = y0;
		chroma_blue = cb;
		luma_second = y1;
		chroma_red  = cr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pair.first  = has_given ? given_first  : convert_pixel(y0, cb, cr);
		pair.second = has_given ? given_second : convert_pixel(y1, cb, cr);
		pending_pixels.push_back(pair);
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		int waited;
		waited = 0;
		start  = 1'b0;
		while (pending_pixels.size() != 0 && waited < 1000) begin
			@(negedge clk);
			waited++;
		end
		if (pending_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d pixel pairs never arrived", pending_pixels.size()));
			pending_pixels.delete();
		end
		repeat (4) @(negedge clk);
	endtask

	always @(posedge clk) begin
		pixel_pair_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected word %08h %08h", pixel_first,
					pixel_second));
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_first !== want.first)
					report_mismatch($sformatf("pixel_first %08h, want %08h", pixel_first,
						want.first));
				if (pixel_second !== want.second)
					report_mismatch($sformatf("pixel_second %08h, want %08h", pixel_second,
						want.second));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	initial begin
		logic [1:0] fmt_list [PHASES];
		logic [7:0] alpha_list [PHASES];
		int         mode;
		error_count = 0;
		fmt_cfg     = FORMAT_RESET;
		alpha_cfg   = ALPHA_RESET;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		start       = 1'b0;
		luma_first  = '0;
		chroma_blue = '0;
		luma_second = '0;
		chroma_red  = '0;
		fmt_list    = '{FMT_RGB, FMT_BGR, FMT_ARGB, FMT_ARGB, FMT_UNUSED, FMT_ARGB, FMT_RGB};
		alpha_list  = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd170, 8'd0, 8'd0};
		alpha_list[5] = rand_byte();
		alpha_list[6] = rand_byte();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				reg_readback(REG_FORMAT);
				reg_readback(REG_ALPHA);
				foreach (directed_rows[i])
					send_word(directed_rows[i].y0, directed_rows[i].cb, directed_rows[i].y1,
						directed_rows[i].cr, next_gap(1), directed_rows[i].has_given,
						directed_rows[i].given_first, directed_rows[i].given_second);
			end else begin
				drain_pipeline();
				cfg_write(REG_FORMAT, {6'd0, fmt_list[p]});
				cfg_write(REG_ALPHA, alpha_list[p]);
			end
			mode = 0;
			for (int n = 0; n < RANDOM_WORDS; n++) begin
				if (n % 30 == 0)
					mode = $urandom_range(0, 2);
				send_word(rand_byte(), rand_byte(), rand_byte(), rand_byte(), next_gap(mode),
					1'b0, '0, '0);
			end
		end

		drain_pipeline();
		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/y2rgb_pkg.sv
hw/rtl/y2rgb_chroma.sv
hw/rtl/y2rgb_lane.sv
hw/rtl/yuyv_to_rgb_pixel_pair_top.sv
tb/tb.sv
